// ----- design/omv_pkg.sv -----
// Package for the running mean / variance block: field widths, defaults,
// shared-unit opcodes and the control/status structs between sequencer and unit.
// No dependencies.
package omv_pkg;

  // Channel field widths
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 32;
  localparam int VAR_W    = 64;
  localparam int SIGMA_W  = 32;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 32;

  // Step counter of the shared unit, holds up to VAR_W steps
  localparam int STEP_W = 7;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [STEP_W-1:0] steps;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- design/omv_if.sv -----
// Valid/ready channel interfaces for the running mean / variance block.
// Depends on omv_pkg for the field widths.
interface omv_in_if;
  import omv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface omv_out_if;
  import omv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [COUNT_W-1:0]  count;
  logic signed [SAMPLE_W-1:0] running_mean;
  logic        [VAR_W-1:0]    sample_variance;
  logic        [SIGMA_W-1:0]  sample_sigma;

  modport source (output valid, output count, output running_mean,
                  output sample_variance, output sample_sigma, input ready);
  modport sink   (input valid, input count, input running_mean,
                  input sample_variance, input sample_sigma, output ready);
endinterface

// ----- design/omv_iter_unit.sv -----
// Shared bit-serial unit: restoring division (one quotient bit per cycle)
// and integer square root (one root bit per cycle) on one subtractor.
// Depends on omv_pkg.
module omv_iter_unit #(
  parameter int COUNT_BITS = omv_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  omv_pkg::unit_ctl_t                 ctl,
  input  logic [omv_pkg::VAR_W-1:0]          opnd,
  input  logic [COUNT_BITS-1:0]              divisor,
  output omv_pkg::unit_stat_t                stat,
  output logic [omv_pkg::VAR_W-1:0]          quo,
  output logic [omv_pkg::VAR_W/2-1:0]        root
);
  import omv_pkg::*;

  localparam int ROOT_W = VAR_W / 2;
  localparam int SUB_W  = (COUNT_BITS + 1 > ROOT_W + 3) ? COUNT_BITS + 1 : ROOT_W + 3;

  logic [SUB_W-1:0]      rem_r;
  logic [VAR_W-1:0]      q_r;
  logic [ROOT_W-1:0]     root_r;
  logic [COUNT_BITS-1:0] dvs_r;
  op_t                   op_r;
  logic [STEP_W-1:0]     left_r;
  logic                  busy_r;
  logic                  done_r;

  logic [SUB_W-1:0] sub_a;
  logic [SUB_W-1:0] sub_b;
  logic [SUB_W:0]   diff;
  logic             ge;

  // Operand select for the shared subtractor
  always_comb begin
    if (op_r == OP_SQRT) begin
      sub_a = {rem_r[SUB_W-3:0], q_r[VAR_W-1 -: 2]};
      sub_b = SUB_W'({root_r, 2'b01});
    end else begin
      sub_a = {rem_r[SUB_W-2:0], q_r[VAR_W-1]};
      sub_b = SUB_W'(dvs_r);
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[SUB_W];
  end

  // Load on start, then advance one digit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        left_r <= ctl.steps;
        op_r   <= ctl.op;
        dvs_r  <= divisor;
        rem_r  <= '0;
        q_r    <= opnd;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[SUB_W-1:0] : sub_a;
        if (op_r == OP_SQRT) begin
          q_r    <= {q_r[VAR_W-3:0], 2'b00};
          root_r <= {root_r[ROOT_W-2:0], ge};
        end else begin
          q_r <= {q_r[VAR_W-2:0], ge};
        end
        left_r <= left_r - 1'b1;
        if (left_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = q_r;
  assign root      = root_r;

endmodule

// ----- design/online_mean_variance.sv -----
// Running mean and variance by Welford's method, with a bit-serial shared
// divide / square-root unit. Depends on omv_pkg, omv_if and omv_iter_unit.
//
//   Channel   Dir  Fields                                        Transfer
//   in_ch     in   sample (s32, low SAMPLE_BITS used)            valid & ready
//   out_ch    out  count, running_mean, sample_variance, sigma   valid & ready
//
// For each sample the shared unit produces SAMPLE_BITS mean quotient bits and,
// only while the count is above one, also 64 variance quotient bits and 32
// root bits; otherwise the variance and sigma are zero. Around these the
// sequencer steps through its own prepare, multiply, accumulate and start states.
// in_ch.ready is high only while no sample is in flight; a finished result
// sits in the output register, so the next sample is taken while it waits.
// A result still waiting there holds the sequencer in its last state.
// Synchronous active-low reset clears the count, mean, deviation sum and valid.
module online_mean_variance #(
  parameter int SAMPLE_BITS = omv_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = omv_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  omv_in_if.sink     in_ch,
  omv_out_if.source  out_ch
);
  import omv_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DMEAN,
    ST_MULT,
    ST_ACCUM,
    ST_VSTART,
    ST_DVAR,
    ST_SQSTART,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t                        state_r;
  logic                          out_valid_r;
  logic        [COUNT_BITS-1:0]  cnt_r;
  logic signed [SAMPLE_BITS-1:0] mean_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic        [VAR_W-1:0]       m2_r;
  logic        [VAR_W-1:0]       prod_r;
  logic        [VAR_W-1:0]       var_r;
  logic        [SIGMA_W-1:0]     sig_r;
  logic                          neg_r;
  logic        [SAMPLE_BITS-1:0] dmag_r;
  logic        [SAMPLE_BITS-1:0] d2mag_r;

  logic        [COUNT_W-1:0]     out_cnt_r;
  logic signed [SAMPLE_W-1:0]    out_mean_r;
  logic        [VAR_W-1:0]       out_var_r;
  logic        [SIGMA_W-1:0]     out_sig_r;

  logic [SAMPLE_BITS:0]     delta;
  logic [SAMPLE_BITS:0]     delta_neg;
  logic [SAMPLE_BITS-1:0]   dmag_w;
  logic [SAMPLE_BITS-1:0]   mag_w;
  logic [SAMPLE_BITS:0]     mean_ext;
  logic [SAMPLE_BITS:0]     mean_upd;
  logic [2*SAMPLE_BITS-1:0] prod_w;
  logic [VAR_W:0]           acc_w;
  logic                     out_free;

  unit_ctl_t             unit_ctl;
  unit_stat_t            unit_stat;
  logic [VAR_W-1:0]      unit_opnd;
  logic [COUNT_BITS-1:0] unit_dvs;
  logic [VAR_W-1:0]      unit_quo;
  logic [VAR_W/2-1:0]    unit_root;

  // Datapath helpers
  always_comb begin
    mean_ext  = {mean_r[SAMPLE_BITS-1], mean_r};
    delta     = {x_r[SAMPLE_BITS-1], x_r} - mean_ext;
    delta_neg = -delta;
    dmag_w    = delta[SAMPLE_BITS] ? delta_neg[SAMPLE_BITS-1:0] : delta[SAMPLE_BITS-1:0];
    mag_w     = unit_quo[SAMPLE_BITS-1:0];
    mean_upd  = neg_r ? mean_ext - {1'b0, mag_w} : mean_ext + {1'b0, mag_w};
    prod_w    = dmag_r * d2mag_r;
    acc_w     = {1'b0, m2_r} + {1'b0, prod_r};
    out_free  = !out_valid_r || out_ch.ready;
  end

  // Drive the shared unit
  always_comb begin
    unit_ctl.start = 1'b0;
    unit_ctl.op    = OP_DIV;
    unit_ctl.steps = STEP_W'(VAR_W);
    unit_opnd      = m2_r;
    unit_dvs       = cnt_r - 1'b1;
    case (state_r)
      ST_PREP: begin
        unit_ctl.start = 1'b1;
        unit_ctl.steps = STEP_W'(SAMPLE_BITS);
        unit_opnd      = {dmag_w, {(VAR_W - SAMPLE_BITS){1'b0}}};
        unit_dvs       = cnt_r;
      end
      ST_VSTART: begin
        unit_ctl.start = 1'b1;
      end
      ST_SQSTART: begin
        unit_ctl.start = 1'b1;
        unit_ctl.op    = OP_SQRT;
        unit_ctl.steps = STEP_W'(VAR_W / 2);
        unit_opnd      = var_r;
      end
      default: begin
        unit_ctl.start = 1'b0;
      end
    endcase
  end

  omv_iter_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (unit_ctl),
    .opnd    (unit_opnd),
    .divisor (unit_dvs),
    .stat    (unit_stat),
    .quo     (unit_quo),
    .root    (unit_root)
  );

  // Sequencer, running state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      mean_r      <= '0;
      m2_r        <= '0;
    end else begin
      // raise valid on a new result, drop it after a transfer
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            x_r <= in_ch.sample[SAMPLE_BITS-1:0];
            if (cnt_r != CNT_MAX) begin
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          neg_r   <= delta[SAMPLE_BITS];
          dmag_r  <= dmag_w;
          state_r <= ST_DMEAN;
        end
        ST_DMEAN: begin
          if (unit_stat.done) begin
            mean_r  <= mean_upd[SAMPLE_BITS-1:0];
            d2mag_r <= dmag_r - mag_w;
            state_r <= ST_MULT;
          end
        end
        ST_MULT: begin
          prod_r  <= VAR_W'(prod_w);
          state_r <= ST_ACCUM;
        end
        ST_ACCUM: begin
          // saturate the deviation sum instead of wrapping
          m2_r <= acc_w[VAR_W] ? {VAR_W{1'b1}} : acc_w[VAR_W-1:0];
          if (cnt_r > COUNT_BITS'(1)) begin
            state_r <= ST_VSTART;
          end else begin
            var_r   <= '0;
            sig_r   <= '0;
            state_r <= ST_DONE;
          end
        end
        ST_VSTART: begin
          state_r <= ST_DVAR;
        end
        ST_DVAR: begin
          if (unit_stat.done) begin
            var_r   <= unit_quo;
            state_r <= ST_SQSTART;
          end
        end
        ST_SQSTART: begin
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (unit_stat.done) begin
            sig_r   <= SIGMA_W'(unit_root);
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_cnt_r   <= COUNT_W'(cnt_r);
            out_mean_r  <= SAMPLE_W'(mean_r);
            out_var_r   <= var_r;
            out_sig_r   <= sig_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.count           = out_cnt_r;
  assign out_ch.running_mean    = out_mean_r;
  assign out_ch.sample_variance = out_var_r;
  assign out_ch.sample_sigma    = out_sig_r;

`ifndef SYNTHESIS
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=>
      (cnt_r == $past(cnt_r) + 1'b1) || ($past(cnt_r) == CNT_MAX))
    else $error("count did not advance on a sample transfer");

  a_m2_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCUM) |=> (m2_r >= $past(m2_r)))
    else $error("deviation sum decreased");

  a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    unit_ctl.start |-> !unit_stat.busy)
    else $error("shared unit started while busy");

  a_var_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && cnt_r <= COUNT_BITS'(1)) |-> (var_r == '0 && sig_r == '0))
    else $error("variance nonzero with count at most one");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> ((VAR_W'(sig_r) * VAR_W'(sig_r)) <= var_r))
    else $error("sigma squared exceeds variance");
`endif

endmodule
